/* hdl/cwc_pkg.sv */
// shared constants, types and helper functions of the color window centroid unit
`default_nettype none

package cwc_pkg;

    // largest frame the counters and sums are sized for
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // fixed field widths
    localparam int COLOR_W    = 8;
    localparam int SIZE_W     = 11;
    localparam int COORD_W    = 10;
    localparam int HIT_OUT_W  = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // derived widths
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int QW     = (CW > RW) ? CW : RW;
    localparam int HIT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W  = QW + HIT_W;
    localparam int LIM_W  = (SIZE_W > QW + 1) ? SIZE_W : QW + 1;
    localparam int CNT_W  = $clog2(QW + 1);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RED      = 3'd0,
        REG_TARGET_GREEN    = 3'd1,
        REG_TARGET_BLUE     = 3'd2,
        REG_TOLERANCE_RED   = 3'd3,
        REG_TOLERANCE_GREEN = 3'd4,
        REG_TOLERANCE_BLUE  = 3'd5,
        REG_FRAME_WIDTH     = 3'd6,
        REG_FRAME_HEIGHT    = 3'd7
    } cwc_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] target_red;
        logic [COLOR_W-1:0] target_green;
        logic [COLOR_W-1:0] target_blue;
        logic [COLOR_W-1:0] tolerance_red;
        logic [COLOR_W-1:0] tolerance_green;
        logic [COLOR_W-1:0] tolerance_blue;
        logic [SIZE_W-1:0]  frame_width;
        logic [SIZE_W-1:0]  frame_height;
    } cwc_cfg_t;

    // totals of one finished frame
    typedef struct packed {
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
        logic [HIT_W-1:0] total;
    } cwc_frame_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [HIT_W-1:0] divisor;
    } cwc_div_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quotient;
    } cwc_div_rsp_t;

    // |p - t| < d, same as t-d < p < t+d on signed values
    function automatic logic in_window(input logic [COLOR_W-1:0] p,
                                       input logic [COLOR_W-1:0] t,
                                       input logic [COLOR_W-1:0] d);
        logic [COLOR_W+1:0] diff;
        logic [COLOR_W+1:0] neg;
        logic [COLOR_W:0]   mag;
        diff = (COLOR_W+2)'(p) - (COLOR_W+2)'(t);
        neg  = -diff;
        mag  = diff[COLOR_W+1] ? neg[COLOR_W:0] : diff[COLOR_W:0];
        return mag < {1'b0, d};
    endfunction

    // zero acts as one, oversize acts as the maximum
    function automatic logic [LIM_W-1:0] size_limit(input logic [SIZE_W-1:0] size,
                                                    input int unsigned maxv);
        if (size == '0) begin
            return LIM_W'(1);
        end else if (LIM_W'(size) > LIM_W'(maxv)) begin
            return LIM_W'(maxv);
        end else begin
            return LIM_W'(size);
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/cwc_if.sv */
// valid/ready channel interfaces for pixels and frame results
`default_nettype none

interface cwc_pixel_if import cwc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green,
                    output pixel_blue, input ready);
    modport sink   (input valid, input pixel_red, input pixel_green,
                    input pixel_blue, output ready);
endinterface

interface cwc_result_if import cwc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic                 found;
    logic [HIT_OUT_W-1:0] hit_count;

    modport source (output valid, output center_x, output center_y, output found,
                    output hit_count, input ready);
    modport sink   (input valid, input center_x, input center_y, input found,
                    input hit_count, output ready);
endinterface

`default_nettype wire

/* hdl/color_window_centroid_unit.sv */
// top level of the color window centroid unit: config, sequencer and output register
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ------------------------------------------
//  pixel     in   valid / ready    pixel_red, pixel_green, pixel_blue (8 b)
//  result    out  valid / ready    center_x, center_y (10 b), found, hit_count
//  config    in   cfg_we           cfg_index (3 b), cfg_data (11 b)
//
// ordinary pixels stream in back to back while the sequencer is idle
// the last pixel of a frame starts the divisions, which are skipped when nothing matched:
// the two means run one after the other through the single divider, one bit a cycle
// the result sits in an output register, so the next frame streams in while it waits
// reset clears counters, sums and the sequencer, and loads the config reset values
// a stalled result only holds off pixels when the next frame's result is ready too
`default_nettype none

module color_window_centroid_unit import cwc_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    cwc_pixel_if.sink                  pixel,
    cwc_result_if.source               result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_XSTART,
        S_XRUN,
        S_YSTART,
        S_YRUN,
        S_EMIT
    } state_t;

    state_t               state_reg,     state_next;
    cwc_cfg_t             cfg_reg,       cfg_next;
    logic [COORD_W-1:0]   cx_reg,        cx_next;
    logic [COORD_W-1:0]   cy_reg,        cy_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_x_reg,     out_x_next;
    logic [COORD_W-1:0]   out_y_reg,     out_y_next;
    logic                 out_found_reg, out_found_next;
    logic [HIT_OUT_W-1:0] out_hit_reg,   out_hit_next;

    logic                 fire;
    logic                 frame_end;
    cwc_frame_t           fin;
    cwc_div_req_t         div_req;
    cwc_div_rsp_t         div_rsp;

    // pixels only enter while the sequencer is idle
    assign pixel.ready = (state_reg == S_IDLE);
    assign fire        = pixel.valid && pixel.ready;

    cwc_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .pixel_red   (pixel.pixel_red),
        .pixel_green (pixel.pixel_green),
        .pixel_blue  (pixel.pixel_blue),
        .cfg         (cfg_reg),
        .frame_end   (frame_end),
        .fin         (fin)
    );

    // divider input: column sum first, then row sum, both over the match count
    always_comb
    begin
        div_req.start    = ((state_reg == S_XSTART) && (fin.total != '0)) ||
                           (state_reg == S_YSTART);
        div_req.dividend = (state_reg == S_YSTART) ? fin.row_sum : fin.col_sum;
        div_req.divisor  = fin.total;
    end

    cwc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_found_next = out_found_reg;
        out_hit_next   = out_hit_reg;

        // config write port
        if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_RED:      cfg_next.target_red      = cfg_data[COLOR_W-1:0];
                REG_TARGET_GREEN:    cfg_next.target_green    = cfg_data[COLOR_W-1:0];
                REG_TARGET_BLUE:     cfg_next.target_blue     = cfg_data[COLOR_W-1:0];
                REG_TOLERANCE_RED:   cfg_next.tolerance_red   = cfg_data[COLOR_W-1:0];
                REG_TOLERANCE_GREEN: cfg_next.tolerance_green = cfg_data[COLOR_W-1:0];
                REG_TOLERANCE_BLUE:  cfg_next.tolerance_blue  = cfg_data[COLOR_W-1:0];
                REG_FRAME_WIDTH:     cfg_next.frame_width     = cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT:    cfg_next.frame_height    = cfg_data[SIZE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end

        // output register drains independently of the sequencer
        if (out_valid_reg && result.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (fire && frame_end) begin
                    state_next = S_XSTART;
                end
            end
            S_XSTART:
            begin
                // no match: skip the divisions and report zeros
                if (fin.total == '0) begin
                    cx_next    = '0;
                    cy_next    = '0;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_XRUN;
                end
            end
            S_XRUN:
            begin
                if (div_rsp.done) begin
                    cx_next    = COORD_W'(div_rsp.quotient);
                    state_next = S_YSTART;
                end
            end
            S_YSTART:
            begin
                state_next = S_YRUN;
            end
            S_YRUN:
            begin
                if (div_rsp.done) begin
                    cy_next    = COORD_W'(div_rsp.quotient);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // load once the previous result has left
                if (!out_valid_reg || result.ready) begin
                    out_valid_next = 1'b1;
                    out_x_next     = cx_reg;
                    out_y_next     = cy_reg;
                    out_found_next = (fin.total != '0);
                    out_hit_next   = HIT_OUT_W'(fin.total);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg                   <= S_IDLE;
            cfg_reg.target_red          <= '0;
            cfg_reg.target_green        <= '0;
            cfg_reg.target_blue         <= '0;
            cfg_reg.tolerance_red       <= '0;
            cfg_reg.tolerance_green     <= '0;
            cfg_reg.tolerance_blue      <= '0;
            cfg_reg.frame_width         <= WIDTH_RESET;
            cfg_reg.frame_height        <= HEIGHT_RESET;
            cx_reg                      <= '0;
            cy_reg                      <= '0;
            out_valid_reg               <= 1'b0;
            out_x_reg                   <= '0;
            out_y_reg                   <= '0;
            out_found_reg               <= 1'b0;
            out_hit_reg                 <= '0;
        end else begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_found_reg <= out_found_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.center_x  = out_x_reg;
    assign result.center_y  = out_y_reg;
    assign result.found     = out_found_reg;
    assign result.hit_count = out_hit_reg;

    // last pixel of a frame hands over to the divider
    a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && frame_end) |=> !pixel.ready)
        else $error("pixel taken while frame result is pending");

    a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.found == (result.hit_count != '0)))
        else $error("found flag disagrees with hit count");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.found) |-> (result.center_x == '0 && result.center_y == '0))
        else $error("empty frame reports a nonzero center");

    a_div_only_when_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_XRUN || state_reg == S_YRUN))
        else $error("divider finished outside a run state");

endmodule

`default_nettype wire

/* hdl/cwc_accum.sv */
// raster position counters, color window test and running sums
`default_nettype none

module cwc_accum import cwc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [COLOR_W-1:0] pixel_red,
    input  wire logic [COLOR_W-1:0] pixel_green,
    input  wire logic [COLOR_W-1:0] pixel_blue,
    input  wire cwc_cfg_t           cfg,
    output logic                    frame_end,
    output cwc_frame_t              fin
);

    logic [CW-1:0]    col_reg,     col_next;
    logic [RW-1:0]    row_reg,     row_next;
    logic [SUM_W-1:0] col_sum_reg, col_sum_next;
    logic [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [HIT_W-1:0] total_reg,   total_next;
    cwc_frame_t       fin_reg,     fin_next;

    logic             match;
    logic             last_col;
    logic             last_row;
    logic [LIM_W-1:0] w_lim;
    logic [LIM_W-1:0] h_lim;
    logic [SUM_W-1:0] col_sum_add;
    logic [SUM_W-1:0] row_sum_add;
    logic [HIT_W-1:0] total_add;

    always_comb
    begin
        match = in_window(pixel_red,   cfg.target_red,   cfg.tolerance_red) &&
                in_window(pixel_green, cfg.target_green, cfg.tolerance_green) &&
                in_window(pixel_blue,  cfg.target_blue,  cfg.tolerance_blue);
        w_lim = size_limit(cfg.frame_width,  MAX_WIDTH);
        h_lim = size_limit(cfg.frame_height, MAX_HEIGHT);
        last_col  = (LIM_W'(col_reg) + LIM_W'(1)) >= w_lim;
        last_row  = (LIM_W'(row_reg) + LIM_W'(1)) >= h_lim;
        frame_end = last_col && last_row;

        col_sum_add = col_sum_reg + (match ? SUM_W'(col_reg) : '0);
        row_sum_add = row_sum_reg + (match ? SUM_W'(row_reg) : '0);
        total_add   = total_reg + (match ? HIT_W'(1) : '0);

        col_next     = col_reg;
        row_next     = row_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        total_next   = total_reg;
        fin_next     = fin_reg;

        if (fire) begin
            if (frame_end) begin
                fin_next.col_sum = col_sum_add;
                fin_next.row_sum = row_sum_add;
                fin_next.total   = total_add;
                col_next     = '0;
                row_next     = '0;
                col_sum_next = '0;
                row_sum_next = '0;
                total_next   = '0;
            end else begin
                col_sum_next = col_sum_add;
                row_sum_next = row_sum_add;
                total_next   = total_add;
                if (last_col) begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            total_reg   <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
            total_reg   <= total_next;
        end
    end

    // frame totals, payload only
    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    assign fin = fin_reg;

    // a mean can never reach past the frame edge
    a_col_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_sum_reg <= SUM_W'(total_reg) * SUM_W'(MAX_WIDTH - 1))
        else $error("column sum exceeds its bound");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && frame_end) |=> (total_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("frame state not cleared after last pixel");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= HIT_W'(MAX_WIDTH * MAX_HEIGHT))
        else $error("match total exceeds frame size");

endmodule

`default_nettype wire

/* hdl/cwc_divider.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module cwc_divider import cwc_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cwc_div_req_t req,
    output cwc_div_rsp_t      rsp
);

    logic             busy_reg,    busy_next;
    logic             done_reg,    done_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [HIT_W-1:0] rem_reg,     rem_next;
    logic [QW-1:0]    quo_reg,     quo_next;
    logic [HIT_W-1:0] divisor_reg, divisor_next;

    logic [HIT_W:0]   trial;
    logic [HIT_W:0]   diff;
    logic             ge;
    logic [QW:0]      shifted;

    always_comb
    begin
        trial   = {rem_reg, quo_reg[QW-1]};
        diff    = trial - {1'b0, divisor_reg};
        ge      = trial >= {1'b0, divisor_reg};
        shifted = {quo_reg, ge};

        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;

        if (req.start) begin
            // upper part is already below the divisor since the mean fits QW bits
            rem_next     = req.dividend[SUM_W-1:QW];
            quo_next     = req.dividend[QW-1:0];
            divisor_next = req.divisor;
            cnt_next     = CNT_W'(QW);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[HIT_W-1:0] : trial[HIT_W-1:0];
            quo_next = shifted[QW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_fits: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (req.dividend[SUM_W-1:QW] < req.divisor))
        else $error("quotient would not fit");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (busy_reg && cnt_reg == CNT_W'(QW)))
        else $error("divider did not start");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished run");

endmodule

`default_nettype wire
